[rtl/pfm_pkg.sv]
// shared types and constants for the period capture frequency meter
// no dependencies; used by period_capture_frequency_meter
`default_nettype none

package pfm_pkg;

	localparam int CLOCK_W     = 27;
	localparam int BCD_DIGITS  = 10;
	localparam int BCD_W       = 4 * BCD_DIGITS;
	localparam int DIGITS_W    = 32;
	localparam int STEP_W      = $clog2(CLOCK_W);
	localparam int APB_DATA_W  = 32;
	localparam int APB_ADDR_W  = 3;

	localparam logic [CLOCK_W-1:0] CLOCK_RESET = 27'd15100000;
	localparam logic [STEP_W-1:0]  LAST_STEP   = STEP_W'(CLOCK_W - 1);

	// register index carried in paddr[2]
	localparam logic REG_CLOCK_HZ = 1'b0;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_BCD,
		S_LOAD
	} state_t;

endpackage

`default_nettype wire

[rtl/period_capture_frequency_meter.sv]
// period capture frequency meter: pairs capture stamps, divides clock_hz by the
// period with a serial restoring divider, then converts with a shift-add-3 unit
// depends on pfm_pkg
//
// usage:
//   capture_time beats come in on in_valid / in_stall. the first beat of a pair
//   is stored and gives no result. the second beat gives one
//   result on out_valid / out_stall: frequency = floor(clock_hz / period),
//   digits_bcd = low DIGIT_COUNT decimal digits, zero_period for equal stamps.
//   a nonzero period passes the accept, CLOCK_W (27) divide steps, CLOCK_W (27)
//   bcd steps and the load state; a zero period goes from the accept straight
//   to the load state. both loops run one step per cycle through one subtractor
//   and one digit adjust row, so in_stall stays high until the result is
//   loaded into the output register.
//   when the receiver stalls the result holds in the output register; the next
//   pair is worked on meanwhile and waits in the load state until it is taken.
//   clock_hz sits at apb byte address 0 and may be written only while idle.
//   reset clears the pair flag and the stored stamp, sets clock_hz to
//   15100000 and drops out_valid.
`default_nettype none

module period_capture_frequency_meter #(
	parameter int TIMER_BITS  = 16,
	parameter int DIGIT_COUNT = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// apb configuration
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [pfm_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [pfm_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [pfm_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                  pready,
	// capture input
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [TIMER_BITS-1:0]            capture_time,
	// result output
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [pfm_pkg::CLOCK_W-1:0]      frequency,
	output logic      [pfm_pkg::DIGITS_W-1:0]     digits_bcd,
	output logic                                  zero_period
);

	localparam int RW     = TIMER_BITS + 1;
	localparam int KEEP_W = (4 * DIGIT_COUNT > pfm_pkg::BCD_W) ? pfm_pkg::BCD_W
	                        : 4 * DIGIT_COUNT;
	localparam logic [pfm_pkg::BCD_W-1:0] DIGIT_MASK =
		(KEEP_W >= pfm_pkg::BCD_W) ? {pfm_pkg::BCD_W{1'b1}}
		: ((pfm_pkg::BCD_W'(1) << KEEP_W) - pfm_pkg::BCD_W'(1));

	pfm_pkg::state_t state_q, state_d;

	logic [pfm_pkg::CLOCK_W-1:0] clock_hz_q;
	logic                        have_first_q;
	logic [TIMER_BITS-1:0]       first_time_q;
	logic [TIMER_BITS-1:0]       divisor_q;
	logic [TIMER_BITS-1:0]       rem_q;
	logic [pfm_pkg::CLOCK_W-1:0] dq_q;
	logic [pfm_pkg::CLOCK_W-1:0] quot_q;
	logic [pfm_pkg::BCD_W-1:0]   bcd_q;
	logic                        zero_q;
	logic [pfm_pkg::STEP_W-1:0]  step_q;
	logic                        out_valid_q;
	logic [pfm_pkg::CLOCK_W-1:0] freq_out_q;
	logic [pfm_pkg::DIGITS_W-1:0] digits_out_q;
	logic                        zero_out_q;

	logic                  in_fire;
	logic                  cfg_write;
	logic                  out_free;
	logic                  load_out;
	logic [TIMER_BITS-1:0] period;
	logic                  period_zero;
	logic                  last_step;
	logic [RW-1:0]         rem_shift;
	logic [RW:0]           trial;
	logic                  trial_ge;
	logic [pfm_pkg::BCD_W-1:0] bcd_adj;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (paddr[2] == pfm_pkg::REG_CLOCK_HZ)
	                   ? pfm_pkg::APB_DATA_W'(clock_hz_q) : '0;

	assign in_fire     = in_valid && !in_stall;
	assign period      = capture_time - first_time_q;
	assign period_zero = (period == '0);
	assign last_step   = (step_q == pfm_pkg::LAST_STEP);
	assign out_free    = !out_valid_q || !out_stall;

	// one restoring divide step
	assign rem_shift = {rem_q, dq_q[pfm_pkg::CLOCK_W-1]};
	assign trial     = {1'b0, rem_shift} - {2'b00, divisor_q};
	assign trial_ge  = !trial[RW];

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < pfm_pkg::BCD_DIGITS; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
			                    : bcd_q[4*i +: 4];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pfm_pkg::S_IDLE: begin
				if (in_fire && have_first_q) begin
					state_d = period_zero ? pfm_pkg::S_LOAD : pfm_pkg::S_DIV;
				end
			end
			pfm_pkg::S_DIV: begin
				if (last_step) state_d = pfm_pkg::S_BCD;
			end
			pfm_pkg::S_BCD: begin
				if (last_step) state_d = pfm_pkg::S_LOAD;
			end
			pfm_pkg::S_LOAD: begin
				if (out_free) state_d = pfm_pkg::S_IDLE;
			end
			default: state_d = pfm_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall = 1'b1;
		load_out = 1'b0;
		unique case (state_q)
			pfm_pkg::S_IDLE: in_stall = 1'b0;
			pfm_pkg::S_LOAD: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pfm_pkg::S_IDLE;
			clock_hz_q   <= pfm_pkg::CLOCK_RESET;
			have_first_q <= 1'b0;
			first_time_q <= '0;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write && paddr[2] == pfm_pkg::REG_CLOCK_HZ) begin
				clock_hz_q <= pwdata[pfm_pkg::CLOCK_W-1:0];
			end
			if (in_fire) begin
				have_first_q <= !have_first_q;
				if (!have_first_q) first_time_q <= capture_time;
			end
			if (state_q == pfm_pkg::S_DIV || state_q == pfm_pkg::S_BCD) begin
				step_q <= last_step ? '0 : step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			pfm_pkg::S_IDLE: begin
				if (in_fire && have_first_q) begin
					divisor_q <= period;
					rem_q     <= '0;
					dq_q      <= clock_hz_q;
					quot_q    <= '0;
					bcd_q     <= '0;
					zero_q    <= period_zero;
				end
			end
			pfm_pkg::S_DIV: begin
				rem_q <= trial_ge ? trial[TIMER_BITS-1:0] : rem_shift[TIMER_BITS-1:0];
				dq_q  <= {dq_q[pfm_pkg::CLOCK_W-2:0], trial_ge};
				if (last_step) begin
					quot_q <= {dq_q[pfm_pkg::CLOCK_W-2:0], trial_ge};
				end
			end
			pfm_pkg::S_BCD: begin
				bcd_q <= {bcd_adj[pfm_pkg::BCD_W-2:0], dq_q[pfm_pkg::CLOCK_W-1]};
				dq_q  <= {dq_q[pfm_pkg::CLOCK_W-2:0], 1'b0};
			end
			pfm_pkg::S_LOAD: ;
			default: ;
		endcase
		if (load_out) begin
			freq_out_q   <= quot_q;
			digits_out_q <= pfm_pkg::DIGITS_W'(bcd_q & DIGIT_MASK);
			zero_out_q   <= zero_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign frequency   = freq_out_q;
	assign digits_bcd  = digits_out_q;
	assign zero_period = zero_out_q;

endmodule

`default_nettype wire

[tb/tb.sv]
// self-checking bench for period_capture_frequency_meter: pairs capture stamps,
// predicts frequency, packed bcd digits and the zero period flag in a scoreboard
// depends on pfm_pkg and the period_capture_frequency_meter rtl

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STAMP_W      = 16;
	localparam int DIGITS       = 8;
	localparam int REPORT_LIMIT = 40;
	localparam int PHASES       = 7;
	localparam int PHASE_BEATS  = 200;
	localparam logic [pfm_pkg::APB_ADDR_W-1:0] ADDR_CLOCK_HZ = pfm_pkg::APB_ADDR_W'(0);
	localparam logic [pfm_pkg::APB_ADDR_W-1:0] ADDR_UNUSED   = pfm_pkg::APB_ADDR_W'(4);
	localparam logic [pfm_pkg::CLOCK_W-1:0]    CLOCK_MAX     = {pfm_pkg::CLOCK_W{1'b1}};

	typedef struct packed {
		logic [pfm_pkg::CLOCK_W-1:0]  frequency;
		logic [pfm_pkg::DIGITS_W-1:0] digits_bcd;
		logic                         zero_period;
	} reading_t;

	class meter_scoreboard;
		logic [pfm_pkg::CLOCK_W-1:0] clock_hz;
		bit                          have_first;
		logic [STAMP_W-1:0]          first_time;
		reading_t                    pending_readings[$];
		int unsigned                 failures;
		int unsigned                 stamps_seen;
		int unsigned                 readings_checked;
		int unsigned                 zero_periods;

		function new();
			clock_hz = pfm_pkg::CLOCK_RESET;
			have_first = 0;
			first_time = '0;
			failures = 0;
			stamps_seen = 0;
			readings_checked = 0;
			zero_periods = 0;
		endfunction

		function void write_reg(logic [pfm_pkg::APB_ADDR_W-1:0] addr,
			logic [pfm_pkg::APB_DATA_W-1:0] data);
			// index lives in paddr[2], anything else is dropped
			if (addr[2] == pfm_pkg::REG_CLOCK_HZ)
				clock_hz = data[pfm_pkg::CLOCK_W-1:0];
		endfunction

		function logic [pfm_pkg::DIGITS_W-1:0] packed_digits(
			logic [pfm_pkg::CLOCK_W-1:0] value);
			int unsigned                  v;
			logic [pfm_pkg::DIGITS_W-1:0] p;
			v = value;
			p = '0;
			for (int n = 0; n < DIGITS; n++) begin
				p[4*n +: 4] = 4'(v % 10);
				v = v / 10;
			end
			return p;
		endfunction

		function void note_stamp(logic [STAMP_W-1:0] stamp);
			logic [STAMP_W-1:0] period;
			reading_t           r;
			stamps_seen++;
			if (!have_first) begin
				first_time = stamp;
				have_first = 1;
				return;
			end
			have_first = 0;
			period = stamp - first_time;
			if (period == '0) begin
				r = '{frequency: '0, digits_bcd: '0, zero_period: 1'b1};
				zero_periods++;
			end else begin
				r.frequency = pfm_pkg::CLOCK_W'(32'(clock_hz) / 32'(period));
				r.digits_bcd = packed_digits(r.frequency);
				r.zero_period = 1'b0;
			end
			pending_readings.push_back(r);
		endfunction

		function void check_result(logic [pfm_pkg::CLOCK_W-1:0] f,
			logic [pfm_pkg::DIGITS_W-1:0] d, logic z);
			reading_t e;
			if (pending_readings.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$error("unexpected reading: frequency %0d digits_bcd %h", f, d);
				return;
			end
			e = pending_readings.pop_front();
			readings_checked++;
			if (f !== e.frequency) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$error("frequency: expected %0d, got %0d", e.frequency, f);
			end
			if (d !== e.digits_bcd) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$error("digits_bcd: expected %h, got %h", e.digits_bcd, d);
			end
			if (z !== e.zero_period) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$error("zero_period: expected %0b, got %0b", e.zero_period, z);
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n       = 1'b0;
	logic                           psel         = 1'b0;
	logic                           penable      = 1'b0;
	logic                           pwrite       = 1'b0;
	logic [pfm_pkg::APB_ADDR_W-1:0] paddr        = '0;
	logic [pfm_pkg::APB_DATA_W-1:0] pwdata       = '0;
	logic [pfm_pkg::APB_DATA_W-1:0] prdata;
	logic                           pready;
	logic                           in_valid     = 1'b0;
	logic                           in_stall;
	logic [STAMP_W-1:0]             capture_time = '0;
	logic                           out_valid;
	logic                           out_stall    = 1'b0;
	logic [pfm_pkg::CLOCK_W-1:0]    frequency;
	logic [pfm_pkg::DIGITS_W-1:0]   digits_bcd;
	logic                           zero_period;

	meter_scoreboard sb;
	int unsigned     burst_left  = 0;
	int unsigned     settings    = 0;
	int unsigned     stall_left  = 0;
	logic [1:0]      stall_mode  = 2'd0;

	period_capture_frequency_meter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.capture_time (capture_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frequency    (frequency),
		.digits_bcd   (digits_bcd),
		.zero_period  (zero_period)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("FAIL");
		$finish;
	end

	// beat monitor on both channels, sees pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_stamp(capture_time);
			if (out_valid && !out_stall)
				sb.check_result(frequency, digits_bcd, zero_period);
		end
	end

	// receiver stall pattern, mode is redrawn whenever its countdown runs out
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= 2'($urandom_range(0, 3));
			stall_left <= $urandom_range(50, 400);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(0, 3) == 0);
			2'd2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (stall_left % 16 < 7);
		endcase
	end

	task automatic send_stamp(input logic [STAMP_W-1:0] stamp);
		int unsigned gap;
		in_valid <= 1'b1;
		capture_time <= stamp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			case ($urandom_range(0, 3))
				0: gap = 0;
				1: gap = $urandom_range(1, 8);
				2: gap = $urandom_range(9, 70);
				default: gap = $urandom_range(0, 3);
			endcase
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_pair(input logic [STAMP_W-1:0] a, input logic [STAMP_W-1:0] b);
		send_stamp(a);
		send_stamp(b);
	endtask

	// drain all readings, let a stored first stamp settle, then write and read back
	task automatic configure(input logic [pfm_pkg::APB_ADDR_W-1:0] addr,
		input logic [pfm_pkg::APB_DATA_W-1:0] data);
		in_valid <= 1'b0;
		while (sb.pending_readings.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.write_reg(addr, data);
		settings++;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		paddr <= ADDR_CLOCK_HZ;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== pfm_pkg::APB_DATA_W'(sb.clock_hz)) begin
			sb.failures++;
			$error("clock_hz: expected %0d, got %0d", sb.clock_hz, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [pfm_pkg::CLOCK_W-1:0] hz;
		logic [STAMP_W-1:0]          first;
		logic [STAMP_W-1:0]          period;
		int unsigned                 sent;

		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset clock, extremes, wrap and equal stamps
		send_pair(16'h0000, 16'h0001);
		send_pair(16'hFFFF, 16'h0000);
		send_pair(16'h0000, 16'hFFFF);
		send_pair(16'h1234, 16'h1234);
		send_pair(16'd100, 16'd50);
		send_pair(16'h8000, 16'h8003);
		// top clock written with spare high bits, ninth digit is dropped
		configure(ADDR_CLOCK_HZ, 32'hFFFF_FFFF);
		send_pair(16'h0000, 16'h0001);
		send_pair(16'h0000, 16'hFFFF);
		// write to an unused index is ignored
		configure(ADDR_UNUSED, 32'd5);
		configure(ADDR_CLOCK_HZ, 32'd1);
		send_pair(16'd5, 16'd6);
		send_pair(16'd0, 16'd2);
		// clock of zero gives zero frequency with no error flag
		configure(ADDR_CLOCK_HZ, 32'd0);
		send_pair(16'd10, 16'd20);
		send_pair(16'd7, 16'd7);

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: hz = pfm_pkg::CLOCK_RESET;
				1: hz = CLOCK_MAX;
				2: hz = pfm_pkg::CLOCK_W'($urandom_range(1, 1000));
				3: hz = pfm_pkg::CLOCK_W'($urandom_range(1, 2**20));
				4: hz = pfm_pkg::CLOCK_W'(1);
				5: hz = pfm_pkg::CLOCK_W'($urandom_range(1, CLOCK_MAX));
				default: hz = pfm_pkg::CLOCK_RESET;
			endcase
			configure(ADDR_CLOCK_HZ, {5'($urandom), hz});
			sent = 0;
			while (sent < PHASE_BEATS) begin
				if ($urandom_range(0, 11) == 0) begin
					// lone stamp shifts the pairing
					send_stamp(STAMP_W'($urandom));
					sent += 1;
				end else begin
					first = STAMP_W'($urandom);
					case ($urandom_range(0, 9))
						0: period = '0;
						1, 2: period = STAMP_W'($urandom_range(1, 15));
						3, 4: period = STAMP_W'($urandom_range(16, 1023));
						5: period = STAMP_W'($urandom_range(65000, 65535));
						default: period = STAMP_W'($urandom);
					endcase
					send_pair(first, first + period);
					sent += 2;
				end
			end
		end

		in_valid <= 1'b0;
		while (sb.pending_readings.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("covered %0d capture beats, %0d readings checked (%0d with zero period)",
			sb.stamps_seen, sb.readings_checked, sb.zero_periods);
		$display("over %0d register writes including top, unit, zero and unused index",
			settings);
		if (sb.failures == 0 && sb.pending_readings.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
